[rtl/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and UTF-8 encoding helpers for the UTF-16BE to
// UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	localparam int CP_W    = 21;
	localparam int POS_W   = 3;
	localparam int QDEPTH  = 2;
	localparam int QCNT_W  = 2;

	localparam logic [CP_W-1:0] REP_CHAR  = 21'h00FFFD;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
	localparam logic [5:0]      HI_TAG    = 6'b110110;
	localparam logic [5:0]      LO_TAG    = 6'b110111;
	localparam logic [4:0]      SURR_TAG  = 5'b11011;
	localparam logic [POS_W-1:0] REP_LEN  = 3'd3;

	// One unit of work for the back end: an optional replacement character
	// followed by an optional code point.
	typedef struct packed {
		logic            rep;
		logic            has_cp;
		logic [CP_W-1:0] cp;
	} job_t;

	function automatic logic [POS_W-1:0] utf8_len(input logic [CP_W-1:0] cp);
		logic [POS_W-1:0] len;
		if (cp <= 21'h00007F) begin
			len = 3'd1;
		end else if (cp <= 21'h0007FF) begin
			len = 3'd2;
		end else if (cp <= 21'h00FFFF) begin
			len = 3'd3;
		end else begin
			len = 3'd4;
		end
		return len;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
	                                         input logic [POS_W-1:0] len,
	                                         input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (len)
			3'd1: b = {1'b0, cp[6:0]};
			3'd2: begin
				unique case (idx)
					2'd0:    b = {3'b110, cp[10:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd3: begin
				unique case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				unique case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

[rtl/u16u8_front.sv]
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and turns each transaction into at
// most one job for the byte sequencer.
// ----------------------------------------------------------------------------
module u16u8_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [15:0]          code_unit,
	input  logic                 end_of_string,
	input  logic                 q_full,
	output logic                 push,
	output u16u8_pkg::job_t      push_job
);
	import u16u8_pkg::*;

	logic       high_pending_q;
	logic [9:0] high_bits_q;
	logic       accept;
	logic       is_hi;
	logic       is_lo;
	logic       is_surr;
	logic       store_hi;
	logic [CP_W-1:0] plain_cp;
	logic [CP_W-1:0] pair_cp;
	job_t       job;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign is_hi    = (code_unit[15:10] == HI_TAG);
	assign is_lo    = (code_unit[15:10] == LO_TAG);
	assign is_surr  = (code_unit[15:11] == SURR_TAG);
	assign store_hi = is_hi && !end_of_string;

	assign plain_cp = is_surr ? REP_CHAR : {5'd0, code_unit};
	assign pair_cp  = SUPP_BASE + {1'b0, high_bits_q, code_unit[9:0]};

	always_comb begin
		job.rep    = 1'b0;
		job.has_cp = 1'b0;
		job.cp     = plain_cp;
		if (high_pending_q && is_lo) begin
			job.has_cp = 1'b1;
			job.cp     = pair_cp;
		end else begin
			job.rep    = high_pending_q;
			job.has_cp = !store_hi;
		end
	end

	assign push     = accept && (job.rep || job.has_cp);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q <= 1'b0;
			high_bits_q    <= '0;
		end else if (accept) begin
			// A completing low surrogate clears the hold; otherwise the hold
			// follows whether this unit is a high surrogate to be stored.
			if (high_pending_q && is_lo) begin
				high_pending_q <= 1'b0;
			end else begin
				high_pending_q <= store_hi;
			end
			if (store_hi && !(high_pending_q && is_lo)) begin
				high_bits_q <= code_unit[9:0];
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("front pushed a job into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && high_pending_q && is_lo) |=> !high_pending_q)
		else $error("surrogate hold not released after a completed pair");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !push) |=> high_pending_q)
		else $error("transaction without a job did not store a high surrogate");

endmodule

[rtl/u16u8_queue.sv]
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue that decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
module u16u8_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  u16u8_pkg::job_t      push_job,
	output logic                 full,
	input  logic                 pop,
	output logic                 q_valid,
	output u16u8_pkg::job_t      q_job
);
	import u16u8_pkg::*;

	job_t              entry_q [QDEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue occupancy exceeds its depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from an empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == QCNT_W'(QDEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with occupancy");

endmodule

[rtl/u16u8_back.sv]
// ----------------------------------------------------------------------------
// u16u8_back
// Byte sequencer: walks through the UTF-8 bytes of one job, one byte per
// cycle while the output stage can take it, into a registered output stage.
// ----------------------------------------------------------------------------
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  u16u8_pkg::job_t      q_job,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 last_of_run
);
	import u16u8_pkg::*;

	logic             busy_q;
	job_t             job_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] total_q;
	logic [POS_W-1:0] cp_len_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;

	logic             load_out;
	logic             step;
	logic             fin;
	logic [POS_W-1:0] new_len;
	logic [POS_W-1:0] new_total;
	logic             in_rep;
	logic [POS_W-1:0] cp_pos;
	logic [7:0]       next_byte;

	assign load_out = !out_valid_q || out_ready;
	assign step     = busy_q && load_out;
	assign fin      = step && (pos_q == total_q - 1'b1);
	assign pop      = q_valid && (!busy_q || fin);

	assign new_len   = utf8_len(q_job.cp);
	assign new_total = (q_job.rep ? REP_LEN : '0) + (q_job.has_cp ? new_len : '0);

	// The replacement character always comes first within a job.
	assign in_rep = job_q.rep && (pos_q < REP_LEN);
	assign cp_pos = pos_q - (job_q.rep ? REP_LEN : '0);

	always_comb begin
		if (in_rep) begin
			next_byte = utf8_byte(REP_CHAR, REP_LEN, pos_q[1:0]);
		end else begin
			next_byte = utf8_byte(job_q.cp, cp_len_q, cp_pos[1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q    <= q_job;
			total_q  <= new_total;
			cp_len_q <= new_len;
		end
		if (step) begin
			out_byte_q <= next_byte;
			last_q     <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (step) begin
				pos_q <= pos_q + 1'b1;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q < total_q))
		else $error("byte position ran past the end of the job");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (q_job.rep || q_job.has_cp))
		else $error("sequencer loaded an empty job");

	assert property (@(posedge clk) disable iff (!arst_n)
		(step && !fin) |=> busy_q)
		else $error("sequencer went idle in the middle of a job");

endmodule

[rtl/utf16be_to_utf8_transcoder_unit.sv]
// ----------------------------------------------------------------------------
// utf16be_to_utf8_transcoder_unit
// UTF-16BE code units in, UTF-8 bytes out, with surrogate pairing and
// U+FFFD substitution for unpaired surrogates.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one code unit and an end-of-string
// flag per transaction. Output channel (out_valid/out_ready) carries one UTF-8
// byte per transaction; last_of_run marks the final byte caused by one input.
// A high surrogate is held inside the block and produces no output until the
// next unit arrives; with end_of_string set it yields U+FFFD at once.
// The classifier turns each input into at most one job in a two-entry queue;
// the byte sequencer reads jobs and emits one byte per cycle while out_ready allows.
// The first byte of an input passes the queue entry, the sequencer's job
// register and the output register. An input gives one to six bytes (none
// for a stored high surrogate); the byte sequencer sets the output rate.
// Input is accepted while the queue has room, also while an output byte waits.
// When the receiver stalls, the output register holds, the queue fills and
// in_ready falls. Reset clears the held surrogate, the queue and the output.
// ----------------------------------------------------------------------------
module utf16be_to_utf8_transcoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);
	import u16u8_pkg::*;

	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic q_valid;
	job_t q_job;

	u16u8_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.code_unit     (code_unit),
		.end_of_string (end_of_string),
		.q_full        (q_full),
		.push          (push),
		.push_job      (push_job)
	);

	u16u8_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	u16u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_job       (q_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

[bench/tb_utf16be_to_utf8_transcoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf16be_to_utf8_transcoder_unit
// Self-checking bench for the UTF-16BE to UTF-8 transcoder. A driver feeds
// code units from a queue, a transcoding predictor builds the expected UTF-8
// bytes, and a monitor checks every output transaction against them. Stimulus
// starts with boundary code points and surrogate corner cases, then random
// strings that are mostly well formed with some stray surrogates and noise.
// ----------------------------------------------------------------------------
module tb_utf16be_to_utf8_transcoder_unit;
	import u16u8_pkg::*;

	localparam logic [15:0] HI_FIRST   = 16'hD800;
	localparam logic [15:0] HI_LAST    = 16'hDBFF;
	localparam logic [15:0] LO_FIRST   = 16'hDC00;
	localparam logic [15:0] LO_LAST    = 16'hDFFF;
	localparam logic [CP_W-1:0] MAX_CP = 21'h10FFFF;
	localparam int RANDOM_UNITS  = 336;
	localparam int IDLE_PCT      = 24;
	localparam int QUIET_FROM    = 120;
	localparam int QUIET_TO      = 200;
	localparam int HOLD_AT       = 280;
	localparam int HOLD_CYCLES   = 80;
	localparam int MAX_REPORTS   = 30;

	typedef struct {
		logic [15:0] unit;
		logic        eos;
	} code_unit_item_t;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} utf8_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] code_unit = 16'h0000;
	logic        end_of_string = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last_of_run;

	code_unit_item_t pending_units[$];
	code_unit_item_t next_unit;
	utf8_byte_t      expected_bytes[$];
	logic [7:0]      run_bytes[$];

	// Predictor state: the held high surrogate.
	logic       held_high = 1'b0;
	logic [9:0] held_bits = 10'h000;

	int  total_units;
	int  units_accepted = 0;
	int  bytes_checked = 0;
	int  pairs_joined = 0;
	int  replacements = 0;
	int  mismatches = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  unit_taken = 1'b0;
	bit  quiet;
	bit  send_now;
	int  drain_cycles;

	utf16be_to_utf8_transcoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.code_unit     (code_unit),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
	endtask

	task automatic queue_unit(input logic [15:0] unit, input logic eos);
		code_unit_item_t it;
		it.unit = unit;
		it.eos = eos;
		pending_units.insert(pending_units.size(), it);
	endtask

	function automatic void append_byte(input logic [7:0] value);
		run_bytes.insert(run_bytes.size(), value);
	endfunction

	// Appends the UTF-8 encoding of one code point to the current run.
	function automatic void encode_code_point(input logic [CP_W-1:0] cp_in);
		logic [CP_W-1:0] cp;
		cp = cp_in;
		if (cp > MAX_CP || (cp >= CP_W'(HI_FIRST) && cp <= CP_W'(LO_LAST))) begin
			cp = REP_CHAR;
		end
		if (cp == REP_CHAR) begin
			replacements++;
		end
		if (cp <= 21'h00007F) begin
			append_byte(cp[7:0]);
		end else if (cp <= 21'h0007FF) begin
			append_byte({3'b110, cp[10:6]});
			append_byte({2'b10, cp[5:0]});
		end else if (cp <= 21'h00FFFF) begin
			append_byte({4'b1110, cp[15:12]});
			append_byte({2'b10, cp[11:6]});
			append_byte({2'b10, cp[5:0]});
		end else begin
			append_byte({5'b11110, cp[20:18]});
			append_byte({2'b10, cp[17:12]});
			append_byte({2'b10, cp[11:6]});
			append_byte({2'b10, cp[5:0]});
		end
	endfunction

	// Works out the bytes that one accepted code unit causes.
	function automatic void transcode_unit(input logic [15:0] unit, input logic eos);
		utf8_byte_t      b;
		logic [CP_W-1:0] cp;
		bit              paired;
		paired = 1'b0;
		run_bytes.delete();
		if (held_high) begin
			held_high = 1'b0;
			if (unit >= LO_FIRST && unit <= LO_LAST) begin
				cp = SUPP_BASE + {held_bits, 10'b0} + CP_W'(unit - LO_FIRST);
				encode_code_point(cp);
				pairs_joined++;
				paired = 1'b1;
			end else begin
				encode_code_point(REP_CHAR);
			end
			held_bits = 10'h000;
		end
		if (!paired) begin
			if (unit >= HI_FIRST && unit <= HI_LAST && !eos) begin
				held_high = 1'b1;
				held_bits = unit[9:0];
			end else begin
				encode_code_point(CP_W'(unit));
			end
		end
		foreach (run_bytes[i]) begin
			b.value = run_bytes[i];
			b.last = (i == run_bytes.size() - 1);
			expected_bytes.insert(expected_bytes.size(), b);
		end
	endfunction

	// One random string: mostly valid characters and pairs, some stray
	// surrogates and arbitrary units; the final unit carries end_of_string.
	task automatic add_random_string();
		int          len;
		int          kind;
		logic        eos;
		logic [19:0] v;
		len = $urandom_range(1, 12);
		for (int k = 0; k < len; k++) begin
			kind = $urandom_range(0, 99);
			eos = (k == len - 1);
			if (kind < 30) begin
				queue_unit(16'($urandom_range(0, 16'h007F)), eos);
			end else if (kind < 45) begin
				queue_unit(16'($urandom_range(16'h0080, 16'h07FF)), eos);
			end else if (kind < 65) begin
				if ($urandom_range(0, 1) == 0) begin
					queue_unit(16'($urandom_range(16'h0800, 16'hD7FF)), eos);
				end else begin
					queue_unit(16'($urandom_range(16'hE000, 16'hFFFF)), eos);
				end
			end else if (kind < 85) begin
				v = 20'($urandom_range(0, 20'hFFFFF));
				queue_unit({HI_FIRST[15:10], v[19:10]}, 1'b0);
				queue_unit({LO_FIRST[15:10], v[9:0]}, eos);
			end else if (kind < 90) begin
				queue_unit(16'($urandom_range(LO_FIRST, LO_LAST)), eos);
			end else if (kind < 95) begin
				queue_unit(16'($urandom_range(HI_FIRST, HI_LAST)), eos);
			end else begin
				queue_unit(16'($urandom_range(0, 16'hFFFF)), eos);
			end
		end
	endtask

	assign quiet = units_accepted >= QUIET_FROM && units_accepted < QUIET_TO;

	// Input side: record accepted transactions and predict their bytes.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			transcode_unit(code_unit, end_of_string);
			units_accepted++;
			unit_taken = 1'b1;
		end
	end

	// Driver: hold the payload until taken, then offer the next unit or idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || unit_taken) begin
			unit_taken = 1'b0;
			send_now = quiet || hold_left > 0 || $urandom_range(0, 99) >= IDLE_PCT;
			if (pending_units.size() != 0 && send_now) begin
				next_unit = pending_units.pop_front();
				code_unit <= next_unit.unit;
				end_of_string <= next_unit.eos;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off that backs up the block.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && units_accepted >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	// Monitor: compare every output transaction with the oldest expected byte.
	always @(posedge clk) begin
		utf8_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last_of_run %0b",
					out_byte, last_of_run));
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.value) begin
					report_mismatch($sformatf("byte %0d: out_byte %02h, expected %02h",
						bytes_checked, out_byte, want.value));
				end
				if (last_of_run !== want.last) begin
					report_mismatch($sformatf("byte %0d: last_of_run %0b, expected %0b",
						bytes_checked, last_of_run, want.last));
				end
			end
			bytes_checked++;
		end
	end

	initial begin
		#2ms;
		$display("Timeout with %0d units accepted and %0d bytes outstanding",
			units_accepted, expected_bytes.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		// Boundaries of each UTF-8 length.
		queue_unit(16'h0000, 1'b0);
		queue_unit(16'h007F, 1'b0);
		queue_unit(16'h0080, 1'b0);
		queue_unit(16'h07FF, 1'b0);
		queue_unit(16'h0800, 1'b0);
		queue_unit(16'hD7FF, 1'b0);
		queue_unit(16'hE000, 1'b0);
		queue_unit(16'hFFFF, 1'b1);
		// Lone low surrogates.
		queue_unit(LO_FIRST, 1'b0);
		queue_unit(LO_LAST, 1'b1);
		// Lowest and highest supplementary code points, the last one ending a string.
		queue_unit(HI_FIRST, 1'b0);
		queue_unit(LO_FIRST, 1'b0);
		queue_unit(HI_LAST, 1'b0);
		queue_unit(LO_LAST, 1'b1);
		// Held high surrogate followed by a plain character.
		queue_unit(16'hD834, 1'b0);
		queue_unit(16'h0041, 1'b0);
		// Held high surrogate replaced by another high, which then pairs.
		queue_unit(HI_FIRST, 1'b0);
		queue_unit(HI_LAST, 1'b0);
		queue_unit(16'hDC01, 1'b0);
		// High surrogate at the end of a string.
		queue_unit(16'hDABC, 1'b1);
		// Held high surrogate, then a high surrogate that ends the string.
		queue_unit(16'hD801, 1'b0);
		queue_unit(16'hD802, 1'b1);
		while (pending_units.size() < 22 + RANDOM_UNITS) begin
			add_random_string();
		end
		total_units = pending_units.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (units_accepted < total_units) begin
			@(posedge clk);
		end
		drain_cycles = 0;
		while (expected_bytes.size() != 0 && drain_cycles < 5000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (20) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			report_mismatch($sformatf("%0d expected bytes never arrived",
				expected_bytes.size()));
		end

		$display("Covered %0d code units, %0d UTF-8 bytes checked, %0d surrogate pairs,",
			units_accepted, bytes_checked, pairs_joined);
		$display("%0d replacement characters and %0d mismatches.", replacements, mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
